FILE: hw/rtl/bqra_pkg.sv
// ----------------------------------------------------------------------------
// bqra_pkg
// Types and constants shared by the bounded queue running average core.
// ----------------------------------------------------------------------------
package bqra_pkg;

  localparam int ID_W     = 12;
  localparam int HEIGHT_W = 8;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_REMOVE = 1'b1;

  typedef struct packed {
    logic                kind;
    logic [ID_W-1:0]     record_id;
    logic [HEIGHT_W-1:0] height;
  } item_t;

  typedef struct packed {
    logic [HEIGHT_W-1:0] mean_height;
    logic [ID_W-1:0]     removed_id;
    logic [HEIGHT_W-1:0] removed_height;
    logic                empty_error;
  } result_t;

  typedef struct packed {
    logic [ID_W-1:0]     id;
    logic [HEIGHT_W-1:0] height;
  } rec_t;

  // Per-cell control: load the new record, or take the neighbor's record.
  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctl_t;

endpackage

FILE: hw/rtl/bqra_cell.sv
// ----------------------------------------------------------------------------
// bqra_cell
// One queue slot. Loads a new record or takes the record of its younger
// neighbor when the queue advances.
// ----------------------------------------------------------------------------
module bqra_cell (
  input  logic              clk,
  input  bqra_pkg::cell_ctl_t ctl,
  input  bqra_pkg::rec_t    new_rec,
  input  bqra_pkg::rec_t    neighbor,
  output bqra_pkg::rec_t    rec
);
  import bqra_pkg::*;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      rec <= new_rec;
    end else if (ctl.shift) begin
      rec <= neighbor;
    end
  end

endmodule

FILE: hw/rtl/bqra_div.sv
// ----------------------------------------------------------------------------
// bqra_div
// Restoring divider, one quotient bit per cycle, numerator MSB first.
// ----------------------------------------------------------------------------
module bqra_div #(
  parameter int NUM_W = 13,
  parameter int DEN_W = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quot
);
  import bqra_pkg::*;

  localparam int STEP_W = $clog2(NUM_W + 1);

  logic [DEN_W-1:0]  rem;
  logic [DEN_W-1:0]  divisor;
  logic [NUM_W-1:0]  work;
  logic [STEP_W-1:0] steps;
  logic              busy;
  logic [DEN_W:0]    trial;
  logic              fits;

  assign trial = {rem, work[NUM_W-1]};
  assign fits  = (trial >= {1'b0, divisor});
  assign quot  = work;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= STEP_W'(NUM_W);
      end else if (busy) begin
        steps <= steps - 1'b1;
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // The quotient bits shift into the low end of the numerator register.
  always_ff @(posedge clk) begin
    if (start) begin
      rem     <= '0;
      divisor <= den;
      work    <= num;
    end else if (busy) begin
      if (fits) begin
        rem <= DEN_W'(trial - {1'b0, divisor});
      end else begin
        rem <= trial[DEN_W-1:0];
      end
      work <= {work[NUM_W-2:0], fits};
    end
  end

endmodule

FILE: hw/rtl/bounded_queue_running_average_core.sv
// ----------------------------------------------------------------------------
// bounded_queue_running_average_core
// Bounded FIFO of records with a rounded running mean of the held heights.
// ----------------------------------------------------------------------------
// The item channel carries one transaction per operation: an insert adds a
// record at the tail (dropping the oldest one first when the queue is full),
// a remove takes the oldest record. Every item yields exactly one result
// transaction on the result channel.
// The queue is a row of CAPACITY cells; cell 0 holds the oldest record and
// the row advances one place on a remove from a non-empty queue or on an insert into a full queue.
// A remove goes from S_IDLE to S_DONE, where its result is copied into the
// output register; no new item is taken until the block is back in S_IDLE.
// An insert computes mean = (2*sum + count) / (2*count) in a bit-serial
// divider that yields NUM_W quotient bits (12 for CAPACITY = 5); the result
// passes from S_DIV through S_DONE into the output register, and no new item
// is taken until the block is back in S_IDLE.
// The block takes a new item while the previous result still waits in the
// output register; if the receiver stalls, the next finished result is held
// internally until the output register frees up, and no further item is
// taken meanwhile.
// Reset empties the queue and clears the running sum; cell contents are
// left as they are and are never read before being written.
// ----------------------------------------------------------------------------
module bounded_queue_running_average_core #(
  parameter int CAPACITY = 5
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  bqra_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_ready,
  output bqra_pkg::result_t result
);
  import bqra_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int SUM_W = $clog2(CAPACITY * 255 + 1);
  localparam int NUM_W = $clog2(2 * CAPACITY * 255 + CAPACITY + 1);
  localparam int DEN_W = CNT_W + 1;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] fill_count;
  logic [SUM_W-1:0] height_sum;
  result_t          pending;

  logic             take;
  logic             is_insert;
  logic             full;
  logic [CNT_W-1:0] cnt_next;
  logic [SUM_W-1:0] sum_next;
  logic             div_start;
  logic             div_done;
  logic [NUM_W-1:0] div_num;
  logic [DEN_W-1:0] div_den;
  logic [NUM_W-1:0] div_quot;
  logic             out_free;

  rec_t      cell_rec [CAPACITY];
  cell_ctl_t cell_ctl [CAPACITY];
  rec_t      new_rec;

  assign item_ready = (state == S_IDLE);
  assign take       = item_valid && item_ready;
  assign is_insert  = (item.kind == KIND_INSERT);
  assign full       = (fill_count == CNT_W'(CAPACITY));
  assign out_free   = !result_valid || result_ready;

  assign new_rec.id     = item.record_id;
  assign new_rec.height = item.height;

  // Next count and sum for an insert; a full queue loses its oldest height.
  always_comb begin
    if (full) begin
      cnt_next = fill_count;
      sum_next = height_sum - SUM_W'(cell_rec[0].height) + SUM_W'(item.height);
    end else begin
      cnt_next = fill_count + 1'b1;
      sum_next = height_sum + SUM_W'(item.height);
    end
  end

  assign div_start = take && is_insert;
  assign div_num   = NUM_W'({sum_next, 1'b0}) + NUM_W'(cnt_next);
  assign div_den   = {cnt_next, 1'b0};

  bqra_div #(
    .NUM_W(NUM_W),
    .DEN_W(DEN_W)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (div_num),
    .den  (div_den),
    .done (div_done),
    .quot (div_quot)
  );

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    always_comb begin
      cell_ctl[i].load  = 1'b0;
      cell_ctl[i].shift = 1'b0;
      if (take) begin
        if (is_insert) begin
          cell_ctl[i].shift = full;
          if (full) begin
            cell_ctl[i].load = (i == CAPACITY - 1);
          end else begin
            cell_ctl[i].load = (fill_count == CNT_W'(i));
          end
        end else begin
          cell_ctl[i].shift = (fill_count != '0);
        end
      end
    end

    if (i == CAPACITY - 1) begin : g_last
      bqra_cell u_cell (
        .clk     (clk),
        .ctl     (cell_ctl[i]),
        .new_rec (new_rec),
        .neighbor(new_rec),
        .rec     (cell_rec[i])
      );
    end else begin : g_mid
      bqra_cell u_cell (
        .clk     (clk),
        .ctl     (cell_ctl[i]),
        .new_rec (new_rec),
        .neighbor(cell_rec[i+1]),
        .rec     (cell_rec[i])
      );
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      fill_count   <= '0;
      height_sum   <= '0;
      result_valid <= 1'b0;
    end else begin
      if (state == S_DONE && out_free) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (take) begin
            if (is_insert) begin
              fill_count <= cnt_next;
              height_sum <= sum_next;
              state      <= S_DIV;
            end else begin
              if (fill_count != '0) begin
                fill_count <= fill_count - 1'b1;
                height_sum <= height_sum - SUM_W'(cell_rec[0].height);
              end
              state <= S_DONE;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      if (is_insert) begin
        pending <= '0;
      end else if (fill_count == '0) begin
        pending <= '{mean_height: '0, removed_id: '0, removed_height: '0,
                     empty_error: 1'b1};
      end else begin
        pending <= '{mean_height: '0, removed_id: cell_rec[0].id,
                     removed_height: cell_rec[0].height, empty_error: 1'b0};
      end
    end else if (state == S_DIV && div_done) begin
      pending.mean_height <= div_quot[HEIGHT_W-1:0];
    end
    if (state == S_DONE && out_free) begin
      result <= pending;
    end
  end

endmodule
